### hdl/srmq_pkg.sv
// Shared constants, types and helper functions of the sparse-table range-minimum engine.
package srmq_pkg;

	localparam int DEPTH      = 4096;
	localparam int LEVELS     = 13;
	localparam int VALUE_BITS = 48;

	localparam int FIELD_W = 12;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int WORDS   = LEVELS * DEPTH;
	localparam int ADDR_W  = $clog2(WORDS);
	localparam int NX_W    = ((FIELD_W > LEVELS) ? FIELD_W : LEVELS) + 1;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic REG_TOP_INDEX = 1'b0;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		value_t            wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} ram_req_t;

	typedef struct packed {
		value_t rdata_a;
		value_t rdata_b;
	} ram_rsp_t;

	typedef struct packed {
		logic   valid;
		value_t minimum;
		logic   status;
	} res_t;

	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(lvl) * ADDR_W'(DEPTH) + ADDR_W'(idx);
	endfunction

	function automatic value_t smin(input value_t a, input value_t b);
		return (a <= b) ? a : b;
	endfunction

	function automatic logic [LVL_W-1:0] floor_log2(input logic [FIELD_W:0] x);
		int g;
		g = 0;
		for (int n = 0; n <= FIELD_W; n++) begin
			if (x[n]) begin
				g = n;
			end
		end
		if (g > LEVELS - 1) begin
			g = LEVELS - 1;
		end
		return LVL_W'(g);
	endfunction

	function automatic logic [FIELD_W-1:0] sat_top(input logic [FIELD_W-1:0] top);
		return (32'(top) > DEPTH - 1) ? FIELD_W'(DEPTH - 1) : top;
	endfunction

	function automatic logic load_ok(input logic [FIELD_W-1:0] idx);
		return 32'(idx) < DEPTH;
	endfunction

endpackage

### hdl/srmq_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
module srmq_ram #(
	parameter int WORDS = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(WORDS)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(WORDS)-1:0] raddr_a,
	input  logic [$clog2(WORDS)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### hdl/srmq_cfg.sv
// Configuration register block with the APB-style access port.
module srmq_cfg import srmq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [FIELD_W-1:0] top_eff
);

	logic [FIELD_W-1:0] top_q;
	logic               sel_top;

	assign pready  = 1'b1;
	assign sel_top = (paddr[2] == REG_TOP_INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_top) begin
			top_q <= pwdata[FIELD_W-1:0];
		end
	end

	assign prdata  = sel_top ? PDATA_W'(top_q) : '0;
	assign top_eff = sat_top(top_q);

endmodule

### hdl/srmq_engine.sv
// Sequencer for loads, the level build sweep and range queries over the table memory.
module srmq_engine import srmq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         operation,
	input  value_t             value,
	input  logic [FIELD_W-1:0] left,
	input  logic [FIELD_W-1:0] right,
	input  logic [FIELD_W-1:0] top_eff,
	input  logic               out_free,
	output res_t               res,
	output ram_req_t           ram_req,
	input  ram_rsp_t           ram_rsp
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_QCALC = 3'd1;
	localparam logic [2:0] ST_QRD   = 3'd2;
	localparam logic [2:0] ST_QWAIT = 3'd3;
	localparam logic [2:0] ST_BRD   = 3'd4;
	localparam logic [2:0] ST_BGAP  = 3'd5;

	logic [2:0]         state_q;
	logic [LVL_W-1:0]   k_q;
	logic [NX_W-1:0]    half_q;
	logic [FIELD_W-1:0] i_q;
	logic               bw_vld_s1;
	logic               bw_copy_s1;
	logic [ADDR_W-1:0]  bw_addr_s1;
	logic [FIELD_W-1:0] left_q;
	logic [FIELD_W-1:0] right_q;
	logic [LVL_W-1:0]   g_q;
	logic               err_q;

	logic               item_acc;
	logic [FIELD_W:0]   len;
	logic               q_err;
	logic [FIELD_W:0]   b_raw;
	logic [FIELD_W:0]   b_idx;
	logic [NX_W-1:0]    nx;
	logic               nx_in;
	logic               load_wr;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;

	assign len   = {1'b0, right_q} - {1'b0, left_q} + (FIELD_W+1)'(1);
	assign q_err = (left_q > right_q) || (right_q > top_eff);
	assign b_raw = {1'b0, right_q} + (FIELD_W+1)'(1) - ((FIELD_W+1)'(1) << g_q);
	assign b_idx = (b_raw < {1'b0, left_q}) ? {1'b0, left_q} : b_raw;

	assign nx    = NX_W'(i_q) + half_q;
	assign nx_in = (nx <= NX_W'(top_eff));

	assign load_wr = item_acc && (operation == OP_LOAD) && load_ok(left);

	always_comb begin
		ram_req.we    = bw_vld_s1 || load_wr;
		ram_req.waddr = bw_vld_s1 ? bw_addr_s1 : tbl_addr('0, IDX_W'(left));
		if (bw_vld_s1) begin
			ram_req.wdata = bw_copy_s1 ? ram_rsp.rdata_a : smin(ram_rsp.rdata_a, ram_rsp.rdata_b);
		end else begin
			ram_req.wdata = value;
		end
		if (state_q == ST_BRD) begin
			ram_req.raddr_a = tbl_addr(k_q - LVL_W'(1), IDX_W'(i_q));
			ram_req.raddr_b = nx_in ? tbl_addr(k_q - LVL_W'(1), IDX_W'(nx)) : ram_req.raddr_a;
		end else begin
			ram_req.raddr_a = tbl_addr(g_q, IDX_W'(left_q));
			ram_req.raddr_b = tbl_addr(g_q, IDX_W'(b_idx));
		end
	end

	always_comb begin
		res.valid   = (state_q == ST_QWAIT);
		res.status  = err_q;
		res.minimum = err_q ? '0 : smin(ram_rsp.rdata_a, ram_rsp.rdata_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			half_q    <= '0;
			i_q       <= '0;
			bw_vld_s1 <= 1'b0;
		end else begin
			bw_vld_s1 <= (state_q == ST_BRD);
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc && operation == OP_QUERY) begin
						state_q <= ST_QCALC;
					end else if (item_acc && operation == OP_BUILD && LEVELS > 1) begin
						state_q <= ST_BRD;
						k_q     <= LVL_W'(1);
						half_q  <= NX_W'(1);
						i_q     <= '0;
					end
				end
				ST_QCALC: begin
					state_q <= ST_QRD;
				end
				ST_QRD: begin
					if (out_free) begin
						state_q <= ST_QWAIT;
					end
				end
				ST_QWAIT: begin
					state_q <= ST_IDLE;
				end
				ST_BRD: begin
					if (i_q == top_eff) begin
						i_q     <= '0;
						state_q <= ST_BGAP;
					end else begin
						i_q <= i_q + FIELD_W'(1);
					end
				end
				ST_BGAP: begin
					if (k_q == LVL_W'(LEVELS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + LVL_W'(1);
						half_q  <= half_q << 1;
						state_q <= ST_BRD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			left_q  <= left;
			right_q <= right;
		end
		if (state_q == ST_QCALC) begin
			g_q   <= floor_log2(len);
			err_q <= q_err;
		end
		if (state_q == ST_BRD) begin
			bw_addr_s1 <= tbl_addr(k_q, IDX_W'(i_q));
			bw_copy_s1 <= !nx_in;
		end
	end

`ifndef NO_ASSERTIONS
	a_res_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("Result produced while the output register is occupied.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status |-> res.minimum == '0)
		else $error("Flagged query carries a nonzero minimum.");

	a_build_wb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BRD |=> bw_vld_s1 && !load_wr)
		else $error("Build read not followed by its write-back, or write port clash.");

	a_build_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BRD |-> i_q <= top_eff)
		else $error("Build index ran past the top index.");
`endif

endmodule

### hdl/sparse_table_range_min.sv
// Top level of the sparse-table range-minimum engine.
// Usage: items arrive on the item channel (item_valid, item_stall) with fields
// operation, value, left and right; query answers leave on the result channel
// (result_valid, result_stall) as minimum and status. The top_index register
// is written over the APB-style port and sets the highest covered index.
// A load word is written into level 0 at its accept edge; the next word can be
// accepted in the following cycle. A query steps through the range and level
// computation, the table memory read and the result state; its answer then
// shows up on result_valid, and item_stall is low again at that point. A build
// sweeps every higher level once, one entry per cycle through the two memory
// read ports, with a gap state after each level and item_stall high throughout.
// A stalled answer is held in the output register while new loads and builds
// go on; a following query waits at its read stage until the held answer is
// taken. Reset returns the sequencer to idle, empties the output register and
// clears top_index; the table contents are undefined until loaded.
module sparse_table_range_min import srmq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         operation,
	input  value_t             value,
	input  logic [FIELD_W-1:0] left,
	input  logic [FIELD_W-1:0] right,
	output logic               result_valid,
	input  logic               result_stall,
	output value_t             minimum,
	output logic               status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [FIELD_W-1:0] top_eff;
	ram_req_t           ram_req;
	ram_rsp_t           ram_rsp;
	res_t               res;
	logic               out_valid_q;
	value_t             minimum_q;
	logic               status_q;
	logic [VALUE_BITS-1:0] rd_a;
	logic [VALUE_BITS-1:0] rd_b;

	srmq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.top_eff (top_eff)
	);

	srmq_ram #(
		.WORDS (WORDS),
		.WIDTH (VALUE_BITS)
	) u_ram (
		.clk     (clk),
		.we      (ram_req.we),
		.waddr   (ram_req.waddr),
		.wdata   (ram_req.wdata),
		.raddr_a (ram_req.raddr_a),
		.raddr_b (ram_req.raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign ram_rsp.rdata_a = $signed(rd_a);
	assign ram_rsp.rdata_b = $signed(rd_b);

	srmq_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.value      (value),
		.left       (left),
		.right      (right),
		.top_eff    (top_eff),
		.out_free   (!out_valid_q),
		.res        (res),
		.ram_req    (ram_req),
		.ram_rsp    (ram_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			minimum_q <= res.minimum;
			status_q  <= res.status;
		end
	end

	assign result_valid = out_valid_q;
	assign minimum      = minimum_q;
	assign status       = status_q;

endmodule

### verif/tb.sv
// Testbench for the sparse-table range-minimum engine, with a scoreboard that mirrors the table.
module tb import srmq_pkg::*; ();

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam int         CYCLE_LIMIT = 1_000_000;
	localparam int         LONG_HOLD   = 400;
	localparam int         HOLD_AFTER  = 60;
	localparam value_t     VALUE_MAX   = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam value_t     VALUE_MIN   = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef struct {
		value_t minimum;
		logic   status;
	} answer_t;

	class range_min_board;
		value_t             level_tbl [LEVELS][DEPTH];
		logic [FIELD_W-1:0] top_idx;
		answer_t            awaited [$];
		int                 errors;

		function new();
			top_idx = '0;
			errors = 0;
		endfunction

		function void set_top(input logic [FIELD_W-1:0] t);
			top_idx = t;
		endfunction

		function int covered_top();
			return (int'(top_idx) > DEPTH - 1) ? DEPTH - 1 : int'(top_idx);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function value_t lesser(input value_t a, input value_t b);
			return (a <= b) ? a : b;
		endfunction

		function void rebuild();
			int hi;
			int half;
			hi = covered_top();
			for (int k = 1; k < LEVELS; k++) begin
				half = 1 << (k - 1);
				for (int i = 0; i <= hi; i++) begin
					if (i + half <= hi) begin
						level_tbl[k][i] = lesser(level_tbl[k-1][i], level_tbl[k-1][i+half]);
					end else begin
						level_tbl[k][i] = level_tbl[k-1][i];
					end
				end
			end
		endfunction

		function void note_word(input logic [1:0] op, input value_t val,
				input logic [FIELD_W-1:0] l, input logic [FIELD_W-1:0] r);
			answer_t a;
			int span;
			int g;
			int b;
			case (op)
			OP_LOAD: begin
				if (int'(l) < DEPTH) begin
					level_tbl[0][l] = val;
				end
			end
			OP_BUILD: begin
				rebuild();
			end
			OP_QUERY: begin
				if (l > r || int'(r) > covered_top()) begin
					a.minimum = '0;
					a.status = 1'b1;
				end else begin
					span = int'(r) - int'(l) + 1;
					g = 0;
					while (span > 1) begin
						span = span >> 1;
						g++;
					end
					if (g > LEVELS - 1) begin
						g = LEVELS - 1;
					end
					b = int'(r) + 1 - (1 << g);
					if (b < int'(l)) begin
						b = int'(l);
					end
					a.minimum = lesser(level_tbl[g][l], level_tbl[g][b]);
					a.status = 1'b0;
				end
				awaited.push_back(a);
			end
			default: begin
			end
			endcase
		endfunction

		function void check_answer(input value_t m, input logic s);
			answer_t want;
			if (awaited.size() == 0) begin
				$error("answer with nothing awaited: minimum %0d status %0d", m, s);
				errors++;
			end else begin
				want = awaited.pop_front();
				if (m !== want.minimum) begin
					$error("minimum: expected %0d, got %0d", want.minimum, m);
					errors++;
				end
				if (s !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, s);
					errors++;
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [1:0]         operation = OP_LOAD;
	value_t             value = '0;
	logic [FIELD_W-1:0] left = '0;
	logic [FIELD_W-1:0] right = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	value_t             minimum;
	logic               status;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	range_min_board board = new();
	bit calm = 1'b0;
	int cycle_count = 0;
	int answers_taken = 0;
	int hold_left = 0;
	bit held_once = 1'b0;

	sparse_table_range_min dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (result_valid === 1'b1 && !result_stall) begin
			board.check_answer(minimum, status);
			answers_taken++;
		end
		if (answers_taken >= HOLD_AFTER && !held_once) begin
			held_once = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (calm) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < 19);
		end
	end

	function automatic value_t pick_value();
		case ($urandom_range(7))
		0: return VALUE_MAX;
		1: return VALUE_MIN;
		2: return value_t'(int'($urandom_range(16)) - 8);
		default: return value_t'({$urandom, $urandom});
		endcase
	endfunction

	task automatic send_word(input logic [1:0] op, input value_t v,
			input logic [FIELD_W-1:0] l, input logic [FIELD_W-1:0] r);
		if (!calm) begin
			while ($urandom_range(99) < 19) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		operation <= op;
		value <= v;
		left <= l;
		right <= r;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		board.note_word(op, v, l, r);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic write_top(input logic [FIELD_W-1:0] t);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * REG_TOP_INDEX);
		pwdata <= PDATA_W'({$urandom, t});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_top(t);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_word(input int t);
		int pick;
		int lo;
		int hi;
		pick = $urandom_range(99);
		if (pick < 55) begin
			lo = $urandom_range(t, 0);
			hi = $urandom_range(t, lo);
			send_word(OP_QUERY, pick_value(), FIELD_W'(lo), FIELD_W'(hi));
		end else if (pick < 65) begin
			if (t < DEPTH - 1 && $urandom_range(1) == 1) begin
				send_word(OP_QUERY, pick_value(), FIELD_W'($urandom),
					FIELD_W'($urandom_range(DEPTH - 1, t + 1)));
			end else begin
				lo = $urandom_range(DEPTH - 1, 1);
				send_word(OP_QUERY, pick_value(), FIELD_W'(lo),
					FIELD_W'($urandom_range(lo - 1, 0)));
			end
		end else if (pick < 88) begin
			lo = ($urandom_range(1) == 1) ? $urandom_range(t, 0) : $urandom_range(DEPTH - 1, 0);
			send_word(OP_LOAD, pick_value(), FIELD_W'(lo), FIELD_W'($urandom));
		end else if (pick < 93 && t <= 300) begin
			send_word(OP_BUILD, pick_value(), FIELD_W'($urandom), FIELD_W'($urandom));
		end else begin
			send_word(OP_SPARE, pick_value(), FIELD_W'($urandom), FIELD_W'($urandom));
		end
	endtask

	task automatic run_phase(input int t, input int count, input bit mid_pause);
		drain();
		repeat ((LEVELS - 1) * (board.covered_top() + 2) + 16) @(posedge clk);
		write_top(FIELD_W'(t));
		for (int i = 0; i <= t; i++) begin
			send_word(OP_LOAD, pick_value(), FIELD_W'(i), FIELD_W'($urandom));
		end
		send_word(OP_BUILD, pick_value(), FIELD_W'($urandom), FIELD_W'($urandom));
		send_word(OP_QUERY, pick_value(), '0, FIELD_W'(t));
		send_word(OP_QUERY, pick_value(), '0, '0);
		send_word(OP_QUERY, pick_value(), FIELD_W'(t), FIELD_W'(t));
		for (int n = 0; n < count; n++) begin
			if (mid_pause && n == count / 2) begin
				drain();
			end
			random_word(t);
		end
	endtask

	initial begin
		int phase_tops [8];
		phase_tops = '{127, 1, 2, 37, 0, 100, 15, 0};
		phase_tops[7] = $urandom_range(60, 3);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_SPARE, VALUE_MAX, '1, '1);
		send_word(OP_QUERY, VALUE_MIN, 12'd5, 12'd3);
		send_word(OP_QUERY, '0, 12'd0, 12'd1);
		send_word(OP_QUERY, '1, '1, '1);
		send_word(OP_QUERY, '0, '0, '1);
		send_word(OP_LOAD, VALUE_MAX, '0, '1);
		send_word(OP_QUERY, '0, '0, '0);
		send_word(OP_LOAD, VALUE_MIN, '0, '0);
		send_word(OP_QUERY, '1, '0, '0);
		send_word(OP_LOAD, '1, '1, '0);
		send_word(OP_LOAD, '0, '0, '0);
		send_word(OP_BUILD, VALUE_MIN, '1, '1);
		send_word(OP_QUERY, '0, '0, '0);
		send_word(OP_SPARE, pick_value(), FIELD_W'($urandom), FIELD_W'($urandom));
		send_word(OP_QUERY, '0, '0, '0);

		for (int p = 0; p < 8; p++) begin
			calm = (p == 5);
			run_phase(phase_tops[p], 30, p == 4);
		end
		calm = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
